// ===== hdl/physical_memory_frame_allocator_assert.svh =====
// Assertion macros used by the frame allocator RTL.
`ifndef PHYSICAL_MEMORY_FRAME_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_MEMORY_FRAME_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PMFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pmfa_pkg.sv =====
// Shared types and codes for the physical memory frame allocator.
package pmfa_pkg;

    localparam int ADDR_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int SIZE_W  = 17;
    localparam int NEXT_W  = 9;     // next unissued frame, 0..256

    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_GET   = 2'd2;
    localparam logic [1:0] FUNC_RET   = 2'd3;

    typedef struct packed {
        logic              rd;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_byte_req;

    typedef struct packed {
        logic               get;
        logic               ret;
        logic [FRAME_W-1:0] frame;
    } t_fl_req;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
    } t_fl_resp;

endpackage

// ===== hdl/pmfa_byte_store.sv =====
// Byte-wide synchronous store with a zero-fill sweep after reset.
module pmfa_byte_store #(
    parameter int MEM_DEPTH = 65536
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pmfa_pkg::t_byte_req                i_req,
    output logic [pmfa_pkg::BYTE_W-1:0]        o_rdata,
    output logic                               o_busy
);
    import pmfa_pkg::*;

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] r_rdata;
    logic [AW-1:0]     r_clr_idx;
    logic [AW-1:0]     n_clr_idx;
    logic              r_busy;
    logic              n_busy;
    logic [AW-1:0]     req_idx;
    logic              w_en;
    logic [AW-1:0]     w_idx;
    logic [BYTE_W-1:0] w_data;

    assign req_idx = AW'(i_req.addr);

    // the sweep owns the write port until every byte is zero
    always_comb begin
        w_en   = r_busy | i_req.we;
        w_idx  = r_busy ? r_clr_idx : req_idx;
        w_data = r_busy ? '0 : i_req.wdata;
    end

    always_comb begin
        n_clr_idx = r_clr_idx;
        n_busy    = r_busy;
        if (r_busy) begin
            n_clr_idx = r_clr_idx + AW'(1);
            if (r_clr_idx == AW'(MEM_DEPTH - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else begin
            r_busy    <= n_busy;
            r_clr_idx <= n_clr_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_idx] <= w_data;
        end
        if (i_req.rd) begin
            r_rdata <= mem[req_idx];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// ===== hdl/pmfa_free_list.sv =====
// Frame allocator: return stack in RAM plus the never-issued frame cursor.
module pmfa_free_list #(
    parameter int RETURN_DEPTH = 256,
    parameter int PAGE_SIZE    = 256,
    parameter int SZW          = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmfa_pkg::t_fl_req    i_req,
    input  logic [SZW-1:0]       i_size,
    output pmfa_pkg::t_fl_resp   o_resp
);
    import pmfa_pkg::*;

    localparam int CNTW = $clog2(RETURN_DEPTH + 1);
    localparam int SIW  = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int MW   = SZW + 10;

    logic [FRAME_W-1:0] stack_mem [RETURN_DEPTH];
    logic [FRAME_W-1:0] r_rd;
    logic [CNTW-1:0]    r_count;
    logic [CNTW-1:0]    n_count;
    logic [CNTW-1:0]    cnt_m1;
    logic [NEXT_W-1:0]  r_next;
    logic [NEXT_W-1:0]  n_next;
    logic               r_ok;
    logic               r_from_stack;
    logic [FRAME_W-1:0] r_frame;
    logic [MW-1:0]      frame_end;
    logic               new_avail;
    logic               size_nz;
    logic               do_pop;
    logic               do_new;
    logic               do_push;

    assign cnt_m1  = r_count - CNTW'(1);
    assign size_nz = (i_size != '0);

    // next < size / PAGE_SIZE  <=>  (next + 1) * PAGE_SIZE <= size; cap at 256 frames
    assign frame_end = (MW'(r_next) + MW'(1)) * MW'(PAGE_SIZE);
    assign new_avail = !r_next[NEXT_W-1] && (frame_end <= MW'(i_size));

    assign do_pop  = i_req.get && size_nz && (r_count != '0);
    assign do_new  = i_req.get && size_nz && (r_count == '0) && new_avail;
    assign do_push = i_req.ret && (r_count != CNTW'(RETURN_DEPTH));

    always_comb begin
        n_count = r_count;
        n_next  = r_next;
        if (do_pop) begin
            n_count = cnt_m1;
        end else if (do_push) begin
            n_count = r_count + CNTW'(1);
        end
        if (do_new) begin
            n_next = r_next + NEXT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_next  <= '0;
        end else begin
            r_count <= n_count;
            r_next  <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            stack_mem[r_count[SIW-1:0]] <= i_req.frame;
        end
        if (do_pop) begin
            r_rd <= stack_mem[cnt_m1[SIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok         <= 1'b0;
            r_from_stack <= 1'b0;
        end else if (i_req.get || i_req.ret) begin
            r_ok         <= do_pop | do_new | do_push;
            r_from_stack <= do_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.get || i_req.ret) begin
            r_frame <= do_new ? r_next[FRAME_W-1:0] : '0;
        end
    end

    assign o_resp.ok    = r_ok;
    assign o_resp.frame = r_from_stack ? r_rd : r_frame;

endmodule

// ===== hdl/physical_memory_frame_allocator.sv =====
// Each input beat is read through the registered byte RAM or return stack RAM, and its result
// then goes to the output register; no new beat is taken until that result is loaded there.
// A finished result sits in the output register while the next input beat is taken.
// Reset (i_rst_n low, synchronous) clears the counters and sets mem_size to 65536.
// After reset a zero-fill sweep writes every byte of the store; no input beat is taken meanwhile.
module physical_memory_frame_allocator #(
    parameter int MEM_DEPTH    = 65536,
    parameter int PAGE_SIZE    = 256,
    parameter int RETURN_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmfa_pkg::SIZE_W-1:0]    i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [31:0]                    i_s_tdata,   // addr[15:0], write_data[23:16], frame_in[31:24]
    input  logic [1:0]                     i_s_tuser,   // func[1:0]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [15:0]                    o_m_tdata,   // read_data[7:0], frame_out[15:8]
    output logic [0:0]                     o_m_tuser    // status[0]
);
    import pmfa_pkg::*;

    `include "physical_memory_frame_allocator_assert.svh"

    localparam int CW  = $clog2(MEM_DEPTH + 1);
    localparam int SZW = (CW > SIZE_W) ? CW : SIZE_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic               r_state;
    logic               n_state;
    logic [SIZE_W-1:0]  r_mem_size;
    logic [SZW-1:0]     size_eff;
    logic               addr_ok;
    logic               accept;
    logic               out_load;
    logic [1:0]         r_func;
    logic               r_ok;
    logic               r_out_valid;
    logic               r_out_status;
    logic [BYTE_W-1:0]  r_out_rdata;
    logic [FRAME_W-1:0] r_out_frame;
    logic               res_status;
    logic [BYTE_W-1:0]  res_rdata;
    logic [FRAME_W-1:0] res_frame;
    logic [1:0]         in_func;
    logic [ADDR_W-1:0]  in_addr;
    t_byte_req          byte_req;
    logic [BYTE_W-1:0]  byte_rdata;
    logic               clr_busy;
    t_fl_req            fl_req;
    t_fl_resp           fl_resp;

    assign in_func = i_s_tuser;
    assign in_addr = i_s_tdata[15:0];

    assign size_eff = (SZW'(r_mem_size) > SZW'(MEM_DEPTH)) ? SZW'(MEM_DEPTH)
                                                           : SZW'(r_mem_size);
    assign addr_ok  = (size_eff != '0) && (SZW'(in_addr) < size_eff);

    assign o_s_tready = (r_state == ST_IDLE) && !clr_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_load   = (r_state == ST_RESP) && (!r_out_valid || i_m_tready);

    always_comb begin
        byte_req.rd    = accept && (in_func == FUNC_READ);
        byte_req.we    = accept && (in_func == FUNC_WRITE) && addr_ok;
        byte_req.addr  = in_addr;
        byte_req.wdata = i_s_tdata[23:16];
        fl_req.get     = accept && (in_func == FUNC_GET);
        fl_req.ret     = accept && (in_func == FUNC_RET);
        fl_req.frame   = i_s_tdata[31:24];
    end

    pmfa_byte_store #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (byte_req),
        .o_rdata (byte_rdata),
        .o_busy  (clr_busy)
    );

    pmfa_free_list #(
        .RETURN_DEPTH (RETURN_DEPTH),
        .PAGE_SIZE    (PAGE_SIZE),
        .SZW          (SZW)
    ) u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fl_req),
        .i_size  (size_eff),
        .o_resp  (fl_resp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        res_status = 1'b1;
        res_rdata  = '0;
        res_frame  = '0;
        case (r_func)
            FUNC_READ: begin
                res_status = !r_ok;
                res_rdata  = r_ok ? byte_rdata : '0;
            end
            FUNC_WRITE: begin
                res_status = !r_ok;
            end
            FUNC_GET, FUNC_RET: begin
                res_status = !fl_resp.ok;
                res_frame  = fl_resp.frame;
            end
            default: res_status = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mem_size  <= SIZE_W'(65536);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mem_size <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= in_func;
            r_ok   <= addr_ok;
        end
        if (out_load) begin
            r_out_status <= res_status;
            r_out_rdata  <= res_rdata;
            r_out_frame  <= res_frame;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_frame, r_out_rdata};
    assign o_m_tuser  = r_out_status;

    `PMFA_ASSERT_NOW(a_no_take_while_clearing, clr_busy, !o_s_tready, "beat taken during RAM sweep")
    `PMFA_ASSERT_NEXT(a_accept_to_resp, accept, r_state == ST_RESP, "accepted beat not in response step")
    `PMFA_ASSERT_NEXT(a_load_sets_valid, out_load, r_out_valid, "response load lost")
    `PMFA_ASSERT_NOW(a_one_in_flight, r_state == ST_RESP, !o_s_tready, "second beat taken before result")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the physical memory frame allocator.
module tb;
    import pmfa_pkg::*;

    localparam int unsigned MEM_DEPTH        = 65536;
    localparam int unsigned PAGE_SIZE        = 256;
    localparam int unsigned RET_DEPTH        = 256;
    localparam int unsigned FRAME_LIMIT      = 256;
    localparam logic        STATUS_OK        = 1'b0;
    localparam logic        STATUS_ERR       = 1'b1;
    localparam int          IDLE_PCT         = 19;
    localparam int          SINK_HOLD_CYCLES = 300;
    localparam int          SETTLE_CYCLES    = 4;
    localparam int          SETTLE_LIMIT     = 5000;

    typedef struct packed {
        logic [1:0]         func;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  wdata;
        logic [FRAME_W-1:0] frame_in;
    } t_request;

    typedef struct packed {
        logic               status;
        logic [BYTE_W-1:0]  rdata;
        logic [FRAME_W-1:0] frame_out;
    } t_response;

    class frame_alloc_scoreboard;
        bit [BYTE_W-1:0]  mem_bytes [MEM_DEPTH];
        bit [FRAME_W-1:0] ret_stack [RET_DEPTH];
        int unsigned      ret_count;
        int unsigned      next_free;
        bit [SIZE_W-1:0]  size_reg;
        t_response        expected_responses[$];
        int               fails;
        int               func_count[4];
        int               err_results;
        int               overflows;
        int               empty_gets;

        function new();
            ret_count = 0;
            next_free = 0;
            size_reg  = SIZE_W'(MEM_DEPTH);
            fails     = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        // Work out the response to an accepted request and queue it.
        function void accept_request(t_request req);
            t_response   r;
            int unsigned span;
            int unsigned frames;
            r.status    = STATUS_ERR;
            r.rdata     = '0;
            r.frame_out = '0;
            span   = (size_reg > MEM_DEPTH) ? MEM_DEPTH : size_reg;
            frames = span / PAGE_SIZE;
            if (frames > FRAME_LIMIT) frames = FRAME_LIMIT;
            func_count[req.func]++;
            case (req.func)
                FUNC_READ: begin
                    if (span != 0 && req.addr < span) begin
                        r.rdata  = mem_bytes[req.addr];
                        r.status = STATUS_OK;
                    end
                end
                FUNC_WRITE: begin
                    if (span != 0 && req.addr < span) begin
                        mem_bytes[req.addr] = req.wdata;
                        r.status = STATUS_OK;
                    end
                end
                FUNC_GET: begin
                    if (span != 0) begin
                        if (ret_count > 0) begin
                            ret_count--;
                            r.frame_out = ret_stack[ret_count];
                            r.status    = STATUS_OK;
                        end else if (next_free < frames) begin
                            r.frame_out = FRAME_W'(next_free);
                            next_free++;
                            r.status    = STATUS_OK;
                        end else begin
                            empty_gets++;
                        end
                    end
                end
                default: begin
                    if (ret_count < RET_DEPTH) begin
                        ret_stack[ret_count] = req.frame_in;
                        ret_count++;
                        r.status = STATUS_OK;
                    end else begin
                        overflows++;
                    end
                end
            endcase
            if (r.status == STATUS_ERR) err_results++;
            expected_responses.push_back(r);
        endfunction

        function void check_response(t_response got);
            t_response want;
            if (expected_responses.size() == 0) begin
                $error("unexpected response: status %0d read_data 0x%0h frame_out %0d",
                       got.status, got.rdata, got.frame_out);
                fails++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.rdata !== want.rdata) begin
                $error("read_data: expected 0x%0h, got 0x%0h", want.rdata, got.rdata);
                fails++;
            end
            if (got.frame_out !== want.frame_out) begin
                $error("frame_out: expected %0d, got %0d", want.frame_out, got.frame_out);
                fails++;
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [31:0]       i_s_tdata   = '0;   // addr[15:0], write_data[23:16], frame_in[31:24]
    logic [1:0]        i_s_tuser   = '0;   // func[1:0]
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [15:0]       o_m_tdata;          // read_data[7:0], frame_out[15:8]
    logic [0:0]        o_m_tuser;          // status[0]

    frame_alloc_scoreboard sb = new();

    logic [SIZE_W-1:0] cur_size = SIZE_W'(MEM_DEPTH);
    logic [ADDR_W-1:0] recent_addrs[$];
    bit                src_idle_on    = 1'b1;
    bit                snk_idle_on    = 1'b1;
    bit                sink_hold_req  = 1'b0;
    int                size_settings  = 0;

    physical_memory_frame_allocator dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Response side: check each accepted beat, then pick tready for the next cycle.
    initial begin : result_sink
        t_response got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
                got.status    = o_m_tuser[0];
                got.rdata     = o_m_tdata[7:0];
                got.frame_out = o_m_tdata[15:8];
                sb.check_response(got);
            end
            if (sink_hold_req) begin
                // long back-pressure so the block fills and stalls its input
                sink_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= !(snk_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    function automatic t_request make_req(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                          logic [BYTE_W-1:0] wdata,
                                          logic [FRAME_W-1:0] frame_in);
        t_request req;
        req.func     = func;
        req.addr     = addr;
        req.wdata    = wdata;
        req.frame_in = frame_in;
        return req;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        int unsigned span;
        span = (cur_size > MEM_DEPTH) ? MEM_DEPTH : cur_size;
        case ($urandom_range(0, 5))
            0: return ADDR_W'($urandom);
            1, 2: begin
                if (recent_addrs.size() != 0)
                    return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
                return ADDR_W'($urandom);
            end
            3: return ADDR_W'(span + $urandom_range(0, 2) - 1);   // around the size edge
            default: return (span == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    task automatic send_req(t_request req);
        if (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {req.frame_in, req.wdata, req.addr};
        i_s_tuser  <= req.func;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.accept_request(req);
        if (req.func == FUNC_WRITE) begin
            recent_addrs.push_back(req.addr);
            if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
        end
    endtask

    // Wait for every outstanding response or until SETTLE_LIMIT is reached, then idle for SETTLE_CYCLES of slack.
    task automatic settle();
        int waited;
        waited = 0;
        while (sb.pending() != 0 && waited < SETTLE_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mem_size(logic [SIZE_W-1:0] value);
        i_s_tvalid <= 1'b0;
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.size_reg = value;
        cur_size    = value;
        size_settings++;
    endtask

    task automatic run_phase(logic [SIZE_W-1:0] size, int count, int w_read, int w_write,
                             int w_get, bit idle_on);
        t_request req;
        int       pick;
        set_mem_size(size);
        src_idle_on = idle_on;
        snk_idle_on = idle_on;
        for (int k = 0; k < count; k++) begin
            req.addr     = ADDR_W'($urandom);
            req.wdata    = BYTE_W'($urandom);
            req.frame_in = FRAME_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < w_read) begin
                req.func = FUNC_READ;
                req.addr = pick_addr();
            end else if (pick < w_read + w_write) begin
                req.func = FUNC_WRITE;
                req.addr = pick_addr();
            end else if (pick < w_read + w_write + w_get) begin
                req.func = FUNC_GET;
            end else begin
                req.func = FUNC_RET;
            end
            send_req(req);
        end
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: edges of the store, LIFO order, size edge cases
        set_mem_size(SIZE_W'(MEM_DEPTH));
        send_req(make_req(FUNC_READ,  16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_WRITE, 16'hFFFF, 8'hFF, 8'h00));
        send_req(make_req(FUNC_READ,  16'hFFFF, 8'h00, 8'h00));
        send_req(make_req(FUNC_WRITE, 16'h0000, 8'hA5, 8'h00));
        send_req(make_req(FUNC_READ,  16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_READ,  16'h8000, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_RET,   16'h0000, 8'h00, 8'hFF));
        send_req(make_req(FUNC_RET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));

        // size not a page multiple: three frames, all already issued
        set_mem_size(SIZE_W'(1023));
        send_req(make_req(FUNC_WRITE, 16'h03FF, 8'h5A, 8'h00));
        send_req(make_req(FUNC_WRITE, 16'h0400, 8'h3C, 8'h00));
        send_req(make_req(FUNC_READ,  16'h03FF, 8'h00, 8'h00));
        send_req(make_req(FUNC_READ,  16'h0400, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_RET,   16'h0000, 8'h00, 8'h07));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));

        // disabled device still takes returns
        set_mem_size('0);
        send_req(make_req(FUNC_READ,  16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_WRITE, 16'h0000, 8'h11, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));
        send_req(make_req(FUNC_RET,   16'h0000, 8'h00, 8'h05));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));

        // size beyond the store acts as the full store
        set_mem_size('1);
        send_req(make_req(FUNC_READ,  16'hFFFF, 8'h00, 8'h00));
        send_req(make_req(FUNC_GET,   16'h0000, 8'h00, 8'h00));

        // random: memory traffic under long back-pressure
        set_mem_size(SIZE_W'(MEM_DEPTH));
        sink_hold_req = 1'b1;
        run_phase(SIZE_W'(MEM_DEPTH), 50, 35, 35, 15, 1'b1);
        run_phase(SIZE_W'(256), 10, 30, 30, 20, 1'b1);
        run_phase(SIZE_W'(1023), 10, 30, 30, 20, 1'b1);
        run_phase(SIZE_W'(4096), 10, 30, 30, 20, 1'b1);
        run_phase(SIZE_W'($urandom_range(1, 8191)), 10, 30, 30, 20, 1'b1);
        // drain the allocator to its last frame, no idling on either side
        run_phase(SIZE_W'(MEM_DEPTH), 280, 1, 1, 96, 1'b0);
        // overfill the return stack
        run_phase(SIZE_W'(MEM_DEPTH), 280, 1, 1, 3, 1'b1);
        run_phase('0, 10, 25, 25, 25, 1'b1);
        run_phase('1, 10, 25, 25, 25, 1'b1);
        run_phase(SIZE_W'(MEM_DEPTH - 1), 10, 25, 25, 25, 1'b1);
        run_phase(SIZE_W'(512), 10, 25, 25, 25, 1'b1);

        i_s_tvalid <= 1'b0;
        settle();
        if (sb.pending() != 0) begin
            $error("%0d responses never arrived", sb.pending());
            sb.fails++;
        end
        $display("Covered %0d reads, %0d writes, %0d gets, %0d returns over %0d size settings.",
                 sb.func_count[FUNC_READ], sb.func_count[FUNC_WRITE],
                 sb.func_count[FUNC_GET], sb.func_count[FUNC_RET], size_settings);
        $display("Error responses %0d, including %0d empty-list gets and %0d stack overflows.",
                 sb.err_results, sb.empty_gets, sb.overflows);
        if (sb.fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
